@@ hw/rtl/pid_controller_fixed_point_defines.svh @@
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared property wrappers for the checker of the fixed-point PID controller.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_FIXED_POINT_DEFINES_SVH
`define PID_CONTROLLER_FIXED_POINT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define PIDFX_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define PIDFX_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pidfx_pkg.sv @@
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes and reset values shared by the controller files.
// ----------------------------------------------------------------------------
package pidfx_pkg;

  localparam int DATA_W            = 16;
  localparam int TIME_W            = 32;
  localparam int CFG_IDX_W         = 3;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int MS_PER_S          = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_PERIOD,
    REG_LIMIT_LOW,
    REG_LIMIT_HIGH
  } cfg_reg_e;

  localparam logic        [DATA_W-1:0] PERIOD_RST     = 16'd100;
  localparam logic signed [DATA_W-1:0] LIMIT_LOW_RST  = 16'sd0;
  localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RST = 16'sd255;

endpackage

@@ hw/rtl/pid_controller_fixed_point.sv @@
// ----------------------------------------------------------------------------
// Fixed-point PID controller
// PID loop with integral and output clamps, built from bit-serial
// multipliers and bit-serial dividers that work one bit per clock.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals
//  in       sink       in_valid_i, in_ready_o, measurement_i, now_ms_i, restart_i
//  out      source     out_valid_o, out_ready_i, control_value_o, updated_o
//  cfg      sink       cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// A restart request or a request before the sample period has elapsed goes
// from S_CHECK straight to S_DONE. An update runs the gain products, then the
// product with the elapsed time and then the two dividers, which run side by
// side one quotient bit a cycle. One request is worked on at a time; the next
// is taken while a result waits in the output register. Reset clears the
// control state and the output and loads the register defaults; the datapath
// registers are not reset. The configuration port is always ready.
// ----------------------------------------------------------------------------
module pid_controller_fixed_point #(
  parameter int FRACTION_BITS = pidfx_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pidfx_pkg::DATA_W-1:0] measurement_i,
  input  logic        [pidfx_pkg::TIME_W-1:0] now_ms_i,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pidfx_pkg::DATA_W-1:0] control_value_o,
  output logic                                updated_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic     [pidfx_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [pidfx_pkg::DATA_W-1:0] cfg_data_i
);

  localparam int DW       = pidfx_pkg::DATA_W;
  localparam int TW       = pidfx_pkg::TIME_W;
  localparam int QS       = FRACTION_BITS - 8;
  localparam int NUM_BITS = 2 * TW + QS;
  localparam int QI_W     = FRACTION_BITS + 18;
  localparam int QD_W     = FRACTION_BITS + 35;
  localparam int INT_W    = FRACTION_BITS + 18;
  localparam int ITMP_W   = FRACTION_BITS + 19;
  localparam int SUM_W    = FRACTION_BITS + 38;
  localparam int CNT_W    = $clog2(NUM_BITS);

  localparam logic [CNT_W-1:0] MUL1_LAST = CNT_W'(DW - 1);
  localparam logic [CNT_W-1:0] MUL2_LAST = CNT_W'(TW - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_BITS - 1);
  localparam logic [10:0]      MS_DIV    = 11'(pidfx_pkg::MS_PER_S);
  localparam logic [QI_W-1:0]  STEP_CAP  = QI_W'(1) << (FRACTION_BITS + 17);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_INT   = 4'd5;
  localparam logic [3:0] S_CLI   = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_CLS   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic signed [DW-1:0] setpoint_q, limit_low_q, limit_high_q;
  logic        [DW-1:0] gain_p_q, gain_i_q, gain_d_q, period_q;

  logic [TW-1:0] last_q, last_d;
  logic signed [16:0] prev_q, prev_d;
  logic signed [INT_W-1:0] integ_q, integ_d;
  logic signed [DW-1:0] held_q, held_d;
  logic upd_q, upd_d;

  logic signed [DW-1:0] meas_q, meas_d;
  logic restart_q, restart_d;
  logic [TW-1:0] now_q, now_d, dt_q, dt_d;
  logic err_neg_q, err_neg_d, diff_neg_q, diff_neg_d;
  logic [15:0] errm_q, errm_d;
  logic [16:0] diffm_q, diffm_d;

  logic [31:0] mulp_q, mulp_d, muli_q, muli_d;
  logic [32:0] muld_q, muld_d;
  logic [63:0] mula_q, mula_d;
  logic [64:0] mulb_q, mulb_d;

  logic [9:0]      remi_q, remi_d;
  logic [TW-1:0]   remd_q, remd_d;
  logic [QI_W-1:0] qi_q, qi_d;
  logic            ovf_q, ovf_d;
  logic [QD_W-1:0] qd_q, qd_d;

  logic signed [ITMP_W-1:0] itmp_q, itmp_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;

  logic out_valid_q, out_valid_d, out_upd_q, out_upd_d;
  logic signed [DW-1:0] out_value_q, out_value_d;

  logic [16:0] step_p, step_i;
  logic [17:0] step_dm;
  logic [32:0] step_a;
  logic [33:0] step_b;

  logic signed [16:0] err;
  logic signed [17:0] diff;
  logic [DW-1:0] period_eff;
  logic [10:0] trial_i;
  logic [TW:0] trial_d;
  logic ge_i, ge_d;
  logic [QI_W-1:0] step_val;
  logic signed [ITMP_W-1:0] lo_i, hi_i;
  logic signed [SUM_W-1:0] lo_s, hi_s, p_w, d_w, integ_w, rnd_w, adj_w;

  assign in_ready_o      = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign control_value_o = out_value_q;
  assign updated_o       = out_upd_q;

  // Shift-add multiplier steps: multiplier in the low half, LSB first.
  assign step_p  = {1'b0, mulp_q[31:16]} + (mulp_q[0] ? {1'b0, errm_q} : 17'd0);
  assign step_i  = {1'b0, muli_q[31:16]} + (muli_q[0] ? {1'b0, errm_q} : 17'd0);
  assign step_dm = {1'b0, muld_q[32:16]} + (muld_q[0] ? {1'b0, diffm_q} : 18'd0);
  assign step_a  = {1'b0, mula_q[63:32]} + (mula_q[0] ? {1'b0, muli_q} : 33'd0);
  assign step_b  = {1'b0, mulb_q[64:32]} + (mulb_q[0] ? {1'b0, muld_q} : 34'd0);

  assign err        = {setpoint_q[DW-1], setpoint_q} - {meas_q[DW-1], meas_q};
  assign diff       = {err[16], err} - {prev_q[16], prev_q};
  assign period_eff = (period_q == '0) ? DW'(1) : period_q;

  // Restoring division steps, one quotient bit per cycle.
  assign trial_i = {remi_q, mula_q[63]};
  assign ge_i    = (trial_i >= MS_DIV);
  assign trial_d = {remd_q, mulb_q[63]};
  assign ge_d    = (trial_d >= {1'b0, dt_q});

  assign step_val = (ovf_q || (qi_q[QI_W-1] && (|qi_q[QI_W-2:0]))) ? STEP_CAP : qi_q;

  assign lo_i    = ITMP_W'(limit_low_q) <<< FRACTION_BITS;
  assign hi_i    = ITMP_W'(limit_high_q) <<< FRACTION_BITS;
  assign lo_s    = SUM_W'(limit_low_q) <<< FRACTION_BITS;
  assign hi_s    = SUM_W'(limit_high_q) <<< FRACTION_BITS;
  assign p_w     = $signed(SUM_W'(mulp_q) << QS);
  assign d_w     = $signed(SUM_W'(qd_q));
  assign integ_w = SUM_W'(integ_q);
  assign rnd_w   = $signed({{(SUM_W - FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}});
  assign adj_w   = sum_q + (sum_q[SUM_W-1] ? rnd_w : '0);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    prev_d      = prev_q;
    integ_d     = integ_q;
    held_d      = held_q;
    upd_d       = upd_q;
    meas_d      = meas_q;
    restart_d   = restart_q;
    now_d       = now_q;
    dt_d        = dt_q;
    err_neg_d   = err_neg_q;
    diff_neg_d  = diff_neg_q;
    errm_d      = errm_q;
    diffm_d     = diffm_q;
    mulp_d      = mulp_q;
    muli_d      = muli_q;
    muld_d      = muld_q;
    mula_d      = mula_q;
    mulb_d      = mulb_q;
    remi_d      = remi_q;
    remd_d      = remd_q;
    qi_d        = qi_q;
    ovf_d       = ovf_q;
    qd_d        = qd_q;
    itmp_d      = itmp_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_upd_d   = out_upd_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          meas_d    = measurement_i;
          restart_d = restart_i;
          now_d     = now_ms_i;
          dt_d      = now_ms_i - last_q;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        upd_d = 1'b0;
        if (restart_q) begin
          prev_d  = '0;
          integ_d = '0;
          held_d  = '0;
          last_d  = now_q;
          state_d = S_DONE;
        end else if (dt_q >= TW'(period_eff)) begin
          err_neg_d  = err[16];
          diff_neg_d = diff[17];
          errm_d     = err[16] ? 16'(-err) : err[15:0];
          diffm_d    = diff[17] ? 17'(-diff) : diff[16:0];
          mulp_d     = {16'd0, gain_p_q};
          muli_d     = {16'd0, gain_i_q};
          muld_d     = {17'd0, gain_d_q};
          prev_d     = err;
          last_d     = now_q;
          cnt_d      = MUL1_LAST;
          state_d    = S_MUL1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MUL1: begin
        mulp_d = {step_p, mulp_q[15:1]};
        muli_d = {step_i, muli_q[15:1]};
        muld_d = {step_dm, muld_q[15:1]};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          mula_d  = {32'd0, dt_q};
          mulb_d  = {33'd0, 32'(pidfx_pkg::MS_PER_S)};
          cnt_d   = MUL2_LAST;
          state_d = S_MUL2;
        end
      end
      S_MUL2: begin
        mula_d = {step_a, mula_q[31:1]};
        mulb_d = {step_b, mulb_q[31:1]};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          remi_d  = '0;
          remd_d  = '0;
          qi_d    = '0;
          ovf_d   = 1'b0;
          qd_d    = '0;
          cnt_d   = DIV_LAST;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        mula_d = {mula_q[62:0], 1'b0};
        mulb_d = {mulb_q[64], mulb_q[62:0], 1'b0};
        remi_d = ge_i ? 10'(trial_i - MS_DIV) : trial_i[9:0];
        remd_d = ge_d ? TW'(trial_d - {1'b0, dt_q}) : trial_d[TW-1:0];
        qi_d   = {qi_q[QI_W-2:0], ge_i};
        ovf_d  = ovf_q | qi_q[QI_W-1];
        qd_d   = {qd_q[QD_W-2:0], ge_d};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_INT;
        end
      end
      S_INT: begin
        itmp_d  = err_neg_q ? ITMP_W'(integ_q) - $signed(ITMP_W'(step_val))
                            : ITMP_W'(integ_q) + $signed(ITMP_W'(step_val));
        sum_d   = err_neg_q ? -p_w : p_w;
        state_d = S_CLI;
      end
      S_CLI: begin
        priority if (itmp_q > hi_i) begin
          integ_d = INT_W'(hi_i);
        end else if (itmp_q < lo_i) begin
          integ_d = INT_W'(lo_i);
        end else begin
          integ_d = INT_W'(itmp_q);
        end
        sum_d   = diff_neg_q ? sum_q - d_w : sum_q + d_w;
        state_d = S_SUM;
      end
      S_SUM: begin
        sum_d   = sum_q + integ_w;
        state_d = S_CLS;
      end
      S_CLS: begin
        priority if (sum_q > hi_s) begin
          sum_d = hi_s;
        end else if (sum_q < lo_s) begin
          sum_d = lo_s;
        end else begin
          sum_d = sum_q;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        held_d  = adj_w[FRACTION_BITS+DW-1:FRACTION_BITS];
        upd_d   = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_value_d = held_q;
          out_upd_d   = upd_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      setpoint_q   <= '0;
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      period_q     <= pidfx_pkg::PERIOD_RST;
      limit_low_q  <= pidfx_pkg::LIMIT_LOW_RST;
      limit_high_q <= pidfx_pkg::LIMIT_HIGH_RST;
      last_q       <= '0;
      prev_q       <= '0;
      integ_q      <= '0;
      held_q       <= '0;
      upd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_upd_q    <= 1'b0;
      out_value_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      prev_q      <= prev_d;
      integ_q     <= integ_d;
      held_q      <= held_d;
      upd_q       <= upd_d;
      out_valid_q <= out_valid_d;
      out_upd_q   <= out_upd_d;
      out_value_q <= out_value_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pidfx_pkg::REG_SETPOINT:   setpoint_q   <= $signed(cfg_data_i);
          pidfx_pkg::REG_GAIN_P:     gain_p_q     <= cfg_data_i;
          pidfx_pkg::REG_GAIN_I:     gain_i_q     <= cfg_data_i;
          pidfx_pkg::REG_GAIN_D:     gain_d_q     <= cfg_data_i;
          pidfx_pkg::REG_PERIOD:     period_q     <= cfg_data_i;
          pidfx_pkg::REG_LIMIT_LOW:  limit_low_q  <= $signed(cfg_data_i);
          pidfx_pkg::REG_LIMIT_HIGH: limit_high_q <= $signed(cfg_data_i);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    meas_q     <= meas_d;
    restart_q  <= restart_d;
    now_q      <= now_d;
    dt_q       <= dt_d;
    err_neg_q  <= err_neg_d;
    diff_neg_q <= diff_neg_d;
    errm_q     <= errm_d;
    diffm_q    <= diffm_d;
    mulp_q     <= mulp_d;
    muli_q     <= muli_d;
    muld_q     <= muld_d;
    mula_q     <= mula_d;
    mulb_q     <= mulb_d;
    remi_q     <= remi_d;
    remd_q     <= remd_d;
    qi_q       <= qi_d;
    ovf_q      <= ovf_d;
    qd_q       <= qd_d;
    itmp_q     <= itmp_d;
    sum_q      <= sum_d;
  end

endmodule

@@ hw/rtl/pidfx_checker.sv @@
// ----------------------------------------------------------------------------
// PID controller port checker
// Watches the ports of the fixed-point PID controller over time.
// ----------------------------------------------------------------------------
`include "pid_controller_fixed_point_defines.svh"

module pidfx_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic signed [pidfx_pkg::DATA_W-1:0] measurement_i,
  input logic        [pidfx_pkg::TIME_W-1:0] now_ms_i,
  input logic                                restart_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [pidfx_pkg::DATA_W-1:0] control_value_o,
  input logic                                updated_o,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic     [pidfx_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic        [pidfx_pkg::DATA_W-1:0] cfg_data_i
);

  logic signed [pidfx_pkg::DATA_W-1:0] lim_lo_q, lim_hi_q;
  logic unused_fields;

  assign unused_fields = ^{measurement_i, now_ms_i, restart_i};

  // Shadow copies of the output limits, taken from the configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_lo_q <= pidfx_pkg::LIMIT_LOW_RST;
      lim_hi_q <= pidfx_pkg::LIMIT_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == pidfx_pkg::REG_LIMIT_LOW) begin
        lim_lo_q <= $signed(cfg_data_i);
      end
      if (cfg_index_i == pidfx_pkg::REG_LIMIT_HIGH) begin
        lim_hi_q <= $signed(cfg_data_i);
      end
    end
  end

  `PIDFX_ASSERT_NXT(a_out_stall_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(control_value_o) && $stable(updated_o), "Stalled result changed.")
  `PIDFX_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "A second request was taken while one is in progress.")
  `PIDFX_ASSERT_IMP(a_cfg_always_ready, cfg_valid_i, cfg_ready_o, "Configuration write was stalled.")
  `PIDFX_ASSERT_IMP(a_out_in_limits, out_valid_o && updated_o && (lim_lo_q <= lim_hi_q) && !unused_fields | (out_valid_o && updated_o && (lim_lo_q <= lim_hi_q)), (control_value_o >= lim_lo_q) && (control_value_o <= lim_hi_q), "Updated output lies outside the limits.")

endmodule

bind pid_controller_fixed_point pidfx_checker u_pidfx_checker (.*);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Fixed-point PID controller testbench
// Drives measurement requests with time stamps through the valid/ready input,
// programs gains, set point, sample period and limits between phases, and
// checks every drive value against a cycle-free model of the control law.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int DATA_W        = pidfx_pkg::DATA_W;
  localparam int TIME_W        = pidfx_pkg::TIME_W;
  localparam int CFG_IDX_W     = pidfx_pkg::CFG_IDX_W;
  localparam int MS_PER_S      = pidfx_pkg::MS_PER_S;
  localparam int FB            = pidfx_pkg::FRACTION_BITS_DEF;
  localparam int SETTLE_CYCLES = FB + 130;
  localparam int HOLD_CYCLES   = 600;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 110;

  class control_scoreboard;
    typedef struct packed {
      logic signed [DATA_W-1:0] control_value;
      logic                     updated;
    } drive_t;

    logic signed [DATA_W-1:0] setpoint;
    logic        [DATA_W-1:0] gain_p;
    logic        [DATA_W-1:0] gain_i;
    logic        [DATA_W-1:0] gain_d;
    logic        [DATA_W-1:0] period_ms;
    logic signed [DATA_W-1:0] limit_low;
    logic signed [DATA_W-1:0] limit_high;

    logic        [TIME_W-1:0] last_ms;
    longint                   prev_err;
    longint                   integ;
    logic signed [DATA_W-1:0] held;

    drive_t pending_drives[$];
    int     errors;
    int     results_seen;

    function new();
      setpoint     = '0;
      gain_p       = '0;
      gain_i       = '0;
      gain_d       = '0;
      period_ms    = pidfx_pkg::PERIOD_RST;
      limit_low    = pidfx_pkg::LIMIT_LOW_RST;
      limit_high   = pidfx_pkg::LIMIT_HIGH_RST;
      last_ms      = '0;
      prev_err     = 0;
      integ        = 0;
      held         = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(pidfx_pkg::cfg_reg_e idx, logic [DATA_W-1:0] value);
      case (idx)
        pidfx_pkg::REG_SETPOINT:   setpoint   = value;
        pidfx_pkg::REG_GAIN_P:     gain_p     = value;
        pidfx_pkg::REG_GAIN_I:     gain_i     = value;
        pidfx_pkg::REG_GAIN_D:     gain_d     = value;
        pidfx_pkg::REG_PERIOD:     period_ms  = value;
        pidfx_pkg::REG_LIMIT_LOW:  limit_low  = value;
        pidfx_pkg::REG_LIMIT_HIGH: limit_high = value;
        default: ;
      endcase
    endfunction

    function longint magn(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint clamp_span(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // Works out the drive value that one accepted request produces.
    function void note_request(logic signed [DATA_W-1:0] meas, logic [TIME_W-1:0] now,
                               bit rs);
      drive_t              want;
      logic [TIME_W-1:0]   dt;
      longint              dtl, period, qscale, cap, lo, hi, err, p, d, sum;
      longint              m, q, r, stp, diff, dm;
      dt     = now - last_ms;
      dtl    = longint'(dt);
      period = (period_ms == 0) ? 1 : longint'(period_ms);
      want.updated = 1'b0;
      if (rs) begin
        prev_err = 0;
        integ    = 0;
        held     = '0;
        last_ms  = now;
      end else if (dtl >= period) begin
        qscale = longint'(1) << (FB - 8);
        cap    = longint'(1) << (FB + 17);
        lo     = longint'(limit_low) * (longint'(1) << FB);
        hi     = longint'(limit_high) * (longint'(1) << FB);
        err    = longint'(setpoint) - longint'(meas);
        p      = longint'(gain_p) * err * qscale;

        m = longint'(gain_i) * magn(err) * qscale;
        q = dtl / MS_PER_S;
        r = dtl % MS_PER_S;
        if (q != 0 && m > cap / q) begin
          stp = cap;
        end else begin
          stp = m * q + (m * r) / MS_PER_S;
          if (stp > cap) stp = cap;
        end
        integ = clamp_span(integ + ((err < 0) ? -stp : stp), lo, hi);

        diff = err - prev_err;
        dm   = longint'(gain_d) * magn(diff) * MS_PER_S * qscale / dtl;
        d    = (diff < 0) ? -dm : dm;

        prev_err = err;
        last_ms  = now;
        sum  = clamp_span(p + integ + d, lo, hi);
        held = DATA_W'((sum < 0) ? -(magn(sum) >> FB) : (magn(sum) >> FB));
        want.updated = 1'b1;
      end
      want.control_value = held;
      pending_drives.push_back(want);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] result %0d: %s", $time, results_seen, msg);
    endtask

    task check_result(logic signed [DATA_W-1:0] cv, logic upd);
      drive_t want;
      results_seen++;
      if (pending_drives.size() == 0) begin
        report_mismatch($sformatf("drive %0d updated %0b with no request pending", cv, upd));
        return;
      end
      want = pending_drives.pop_front();
      if (cv !== want.control_value)
        report_mismatch($sformatf("control_value %0d, expected %0d", cv,
                                  want.control_value));
      if (upd !== want.updated)
        report_mismatch($sformatf("updated %0b, expected %0b", upd, want.updated));
    endtask
  endclass

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] measurement_i = '0;
  logic [TIME_W-1:0]        now_ms_i      = '0;
  logic                     restart_i     = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic signed [DATA_W-1:0] control_value_o;
  logic                     updated_o;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i   = '0;
  logic [DATA_W-1:0]        cfg_data_i    = '0;

  control_scoreboard sb;
  logic [TIME_W-1:0] clock_ms     = '0;
  int                burst_left   = 0;
  bit                hold_request = 1'b0;
  int                idle_cycles  = 0;
  int                stall_mode   = 0;
  int                mode_left    = 0;
  int                pattern_step = 0;

  pid_controller_fixed_point dut (.*);

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(control_value_o, updated_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
        $display("pid_controller_fixed_point regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The receiver switches between stall patterns; a hold request keeps it
  // stalled long enough for the controller to back up its input.
  always begin
    @(negedge clk_i);
    if (hold_request) begin
      hold_request = 1'b0;
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(negedge clk_i);
    end else begin
      if (mode_left == 0) begin
        stall_mode = int'($urandom_range(0, 3));
        mode_left  = int'($urandom_range(20, 200));
      end
      mode_left    = mode_left - 1;
      pattern_step = pattern_step + 1;
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 3) != 0);
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ((pattern_step % 5) < 2);
      endcase
    end
  end

  task automatic send_request(logic signed [DATA_W-1:0] meas, logic [TIME_W-1:0] now,
                              bit rs);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    measurement_i <= meas;
    now_ms_i      <= now;
    restart_i     <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(meas, now, rs);
  endtask

  task automatic send_after(logic [TIME_W-1:0] delta, logic signed [DATA_W-1:0] meas, bit rs);
    clock_ms = clock_ms + delta;
    send_request(meas, clock_ms, rs);
  endtask

  task automatic idle_gap(int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(pidfx_pkg::cfg_reg_e idx, logic [DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(logic [DATA_W-1:0] sp, logic [DATA_W-1:0] kp,
                           logic [DATA_W-1:0] ki, logic [DATA_W-1:0] kd,
                           logic [DATA_W-1:0] per, logic [DATA_W-1:0] lo,
                           logic [DATA_W-1:0] hi);
    write_reg(pidfx_pkg::REG_SETPOINT, sp);
    write_reg(pidfx_pkg::REG_GAIN_P, kp);
    write_reg(pidfx_pkg::REG_GAIN_I, ki);
    write_reg(pidfx_pkg::REG_GAIN_D, kd);
    write_reg(pidfx_pkg::REG_PERIOD, per);
    write_reg(pidfx_pkg::REG_LIMIT_LOW, lo);
    write_reg(pidfx_pkg::REG_LIMIT_HIGH, hi);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return DATA_W'($urandom);
      default: return DATA_W'($urandom_range(0, 16'h0400));
    endcase
  endfunction

  task automatic randomize_settings();
    logic [DATA_W-1:0] lo_v, hi_v, swap_v, per_v;
    lo_v = DATA_W'($urandom);
    hi_v = DATA_W'($urandom);
    case ($urandom_range(0, 7))
      0: begin
        if ($signed(lo_v) < $signed(hi_v)) begin
          swap_v = lo_v;
          lo_v   = hi_v;
          hi_v   = swap_v;
        end
      end
      1: begin
        lo_v = 16'h8000;
        hi_v = 16'h7FFF;
      end
      2, 3: begin
        lo_v = DATA_W'(-$urandom_range(0, 3000));
        hi_v = DATA_W'($urandom_range(0, 3000));
      end
      default: begin
        if ($signed(lo_v) > $signed(hi_v)) begin
          swap_v = lo_v;
          lo_v   = hi_v;
          hi_v   = swap_v;
        end
      end
    endcase
    case ($urandom_range(0, 9))
      0:       per_v = 16'd0;
      1:       per_v = 16'hFFFF;
      2:       per_v = 16'd1;
      default: per_v = DATA_W'($urandom_range(2, 300));
    endcase
    write_all(pick_value(), pick_gain(), pick_gain(), pick_gain(), per_v, lo_v, hi_v);
  endtask

  task automatic random_request();
    logic [TIME_W-1:0]        delta;
    logic signed [DATA_W-1:0] meas;
    int                       eff;
    bit                       rs;
    eff = (sb.period_ms == 0) ? 1 : int'(sb.period_ms);
    rs  = ($urandom_range(0, 24) == 0);
    case ($urandom_range(0, 9))
      0, 1:       delta = $urandom_range(0, eff - 1);
      2:          delta = eff;
      3, 4, 5, 6: delta = eff + $urandom_range(0, 1500);
      7:          delta = $urandom_range(1000, 200000);
      8:          delta = $urandom;
      default:    delta = $urandom_range(0, 3);
    endcase
    case ($urandom_range(0, 7))
      0:       meas = 16'h8000;
      1:       meas = 16'h7FFF;
      2, 3:    meas = DATA_W'(sb.setpoint + $urandom_range(0, 64) - 32);
      default: meas = DATA_W'($urandom);
    endcase
    send_after(delta, meas, rs);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: zero gains, period 100, limits 0 to 255.
    send_after(100, 16'sd10, 1'b0);
    send_after(50, 16'sd20, 1'b0);

    wait_drained();
    write_all(16'sd1000, 16'h0180, 16'h0200, 16'h0040, 16'd10, -16'sd2000, 16'sd2000);
    send_after(5, 16'sd0, 1'b1);
    send_after(10, 16'sd900, 1'b0);
    send_after(5, 16'sd800, 1'b0);
    send_after(7, 16'sd800, 1'b0);
    send_after(1500, 16'h8000, 1'b0);
    send_after(2000, 16'h7FFF, 1'b0);
    clock_ms = 32'hFFFF_FFF0;
    send_after(0, 16'sd950, 1'b1);
    send_after(32, 16'sd1100, 1'b0);
    send_after(32'h8000_0000, 16'sd0, 1'b0);

    // Full-scale gains saturate the integral step and span every limit.
    wait_drained();
    write_all(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
    send_after(65535, 16'h7FFF, 1'b0);
    send_after(70000, 16'h8000, 1'b0);
    send_after(32'hFFFF_FFFF, 16'h7FFF, 1'b0);
    send_after(100, 16'sd0, 1'b0);

    // A zero sample period acts as one millisecond; the limits are reversed.
    wait_drained();
    write_all(16'h7FFF, 16'h0100, 16'h0100, 16'h0100, 16'd0, 16'sd100, -16'sd100);
    send_after(0, 16'sd0, 1'b0);
    send_after(1, 16'h8000, 1'b0);
    send_after(1, 16'h7FFF, 1'b0);
    send_after(3, 16'sd1000, 1'b0);

    wait_drained();
    write_all(16'sd0, 16'h0200, 16'h0000, 16'h0000, 16'd1, -16'sd50, 16'sd50);
    send_after(1, 16'sd20, 1'b0);
    send_after(2, -16'sd20, 1'b0);
    send_after(1, 16'sd0, 1'b1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      randomize_settings();
      burst_left = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == 30 && (ph == 1 || ph == 5)) begin
          hold_request = 1'b1;
          burst_left   = 20;
        end else if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) idle_gap(int'($urandom_range(1, 12)));
          burst_left = int'($urandom_range(1, 24));
        end
        burst_left = burst_left - 1;
        random_request();
      end
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("pid_controller_fixed_point regression: pass");
    end else begin
      $display("pid_controller_fixed_point regression: fail");
    end
    $finish;
  end

endmodule
